// ----- hw/rtl/ahsc_pkg.sv -----
// Shared types and constants for the anisotropic heat stencil cell.
package ahsc_pkg;

    localparam int TEMP_W      = 32;
    localparam int LAP_W       = 34;
    localparam int GAIN_W      = 16;
    localparam int SRC_W       = 32;
    localparam int MAT_W       = 2;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_GAIN = 2'd2;

    // one classified cell, ready for the arithmetic back end
    typedef struct packed {
        logic signed [TEMP_W-1:0] centre;
        logic signed [LAP_W-1:0]  lap_x;
        logic signed [LAP_W-1:0]  lap_y;
        logic [GAIN_W-1:0]        gain_x;
        logic [GAIN_W-1:0]        gain_y;
        logic [GAIN_W-1:0]        gain_s;
        logic [SRC_W-1:0]         heat_source;
    } cell_req_t;

endpackage

// ----- hw/rtl/ahsc_front.sv -----
// Front end: gain tables, material lookup and second differences per cell.
module ahsc_front #(
    parameter int MATERIAL_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ahsc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ahsc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_tvalid,
    input  logic [191:0]                        s_tdata,
    input  logic [ahsc_pkg::MAT_W-1:0]          s_tuser,
    output logic                                req_valid,
    output ahsc_pkg::cell_req_t                 req
);

    localparam int MAT_IDX_W = (MATERIAL_COUNT > 1) ? $clog2(MATERIAL_COUNT) : 1;

    logic [ahsc_pkg::GAIN_W-1:0] gx_reg [MATERIAL_COUNT];
    logic [ahsc_pkg::GAIN_W-1:0] gy_reg [MATERIAL_COUNT];
    logic [ahsc_pkg::GAIN_W-1:0] gs_reg [MATERIAL_COUNT];

    logic signed [ahsc_pkg::TEMP_W-1:0] centre, north, south, east, west;
    logic                               mat_ok;
    logic [MAT_IDX_W-1:0]               mat_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < MATERIAL_COUNT; m++) begin
                gx_reg[m] <= '0;
                gy_reg[m] <= '0;
                gs_reg[m] <= '0;
            end
        end else if (cfg_we) begin
            for (int m = 0; m < MATERIAL_COUNT; m++) begin
                if (cfg_index == ahsc_pkg::REG_X_GAIN) begin
                    gx_reg[m] <= cfg_data[m*ahsc_pkg::GAIN_W +: ahsc_pkg::GAIN_W];
                end
                if (cfg_index == ahsc_pkg::REG_Y_GAIN) begin
                    gy_reg[m] <= cfg_data[m*ahsc_pkg::GAIN_W +: ahsc_pkg::GAIN_W];
                end
                if (cfg_index == ahsc_pkg::REG_SOURCE_GAIN) begin
                    gs_reg[m] <= cfg_data[m*ahsc_pkg::GAIN_W +: ahsc_pkg::GAIN_W];
                end
            end
        end
    end

    assign centre = signed'(s_tdata[31:0]);
    assign north  = signed'(s_tdata[63:32]);
    assign south  = signed'(s_tdata[95:64]);
    assign east   = signed'(s_tdata[127:96]);
    assign west   = signed'(s_tdata[159:128]);

    // unknown materials get zero gains
    assign mat_ok  = ({1'b0, s_tuser} < 3'(MATERIAL_COUNT));
    assign mat_idx = mat_ok ? MAT_IDX_W'(s_tuser) : '0;

    assign req_valid = s_tvalid;

    always_comb begin
        req.centre      = centre;
        req.lap_x       = {{2{east[31]}}, east} + {{2{west[31]}}, west}
                        - {centre[31], centre, 1'b0};
        req.lap_y       = {{2{north[31]}}, north} + {{2{south[31]}}, south}
                        - {centre[31], centre, 1'b0};
        req.gain_x      = mat_ok ? gx_reg[mat_idx] : '0;
        req.gain_y      = mat_ok ? gy_reg[mat_idx] : '0;
        req.gain_s      = mat_ok ? gs_reg[mat_idx] : '0;
        req.heat_source = s_tdata[191:160];
    end

endmodule

// ----- hw/rtl/ahsc_queue.sv -----
// Short request queue between the front end and the arithmetic back end.
module ahsc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  ahsc_pkg::cell_req_t push_req,
    output logic                pop_valid,
    input  logic                pop,
    output ahsc_pkg::cell_req_t pop_req
);

    ahsc_pkg::cell_req_t               store_reg [ahsc_pkg::QUEUE_DEPTH];
    logic [ahsc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ahsc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ahsc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    assign push_ready = (count_reg != ahsc_pkg::QCNT_W'(ahsc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_req    = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- hw/rtl/ahsc_back.sv -----
// Back end: gain products, rounding, source term, sum and saturation.
module ahsc_back #(
    parameter int SOURCE_SHIFT = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    input  ahsc_pkg::cell_req_t req,
    output logic                req_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    localparam int PROD_W   = ahsc_pkg::LAP_W + ahsc_pkg::GAIN_W + 1;
    localparam int DSUM_W   = PROD_W + 1;
    localparam int DIFF_W   = DSUM_W - 16;
    localparam int PROD_S_W = ahsc_pkg::GAIN_W + ahsc_pkg::SRC_W;
    localparam int HEAT_W   = PROD_S_W - SOURCE_SHIFT;
    localparam int SUM_W    = PROD_S_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-31){1'b1}}, {31{1'b0}}};

    logic                                 en;
    logic                                 a_valid_reg, b_valid_reg, out_valid_reg;
    logic signed [PROD_W-1:0]             px_reg, py_reg, px_next, py_next;
    logic [PROD_S_W-1:0]                  ps_reg, ps_next;
    logic signed [ahsc_pkg::TEMP_W-1:0]   ca_reg, cb_reg;
    logic signed [DSUM_W-1:0]             dsum;
    logic signed [DIFF_W-1:0]             diff_reg, diff_next;
    logic [HEAT_W-1:0]                    heat_reg, heat_next;
    logic signed [SUM_W-1:0]              sum;
    logic [31:0]                          temp_reg, temp_next;
    logic                                 sat_reg, sat_next;

    assign en      = !out_valid_reg || m_tready;
    assign req_pop = en;

    assign px_next = $signed({1'b0, req.gain_x}) * req.lap_x;
    assign py_next = $signed({1'b0, req.gain_y}) * req.lap_y;
    assign ps_next = req.gain_s * req.heat_source;

    // round half up to Q16.16
    assign dsum      = {px_reg[PROD_W-1], px_reg} + {py_reg[PROD_W-1], py_reg}
                     + DSUM_W'(32'h8000);
    assign diff_next = dsum[DSUM_W-1:16];
    assign heat_next = ps_reg[PROD_S_W-1 -: HEAT_W];

    assign sum = {{(SUM_W-ahsc_pkg::TEMP_W){cb_reg[ahsc_pkg::TEMP_W-1]}}, cb_reg}
               + {{(SUM_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg}
               + signed'(SUM_W'(heat_reg));

    always_comb begin
        temp_next = sum[31:0];
        sat_next  = 1'b0;
        if (sum > SAT_HI) begin
            temp_next = 32'h7FFF_FFFF;
            sat_next  = 1'b1;
        end else if (sum < SAT_LO) begin
            temp_next = 32'h8000_0000;
            sat_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= req_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            ps_reg   <= ps_next;
            ca_reg   <= req.centre;
            diff_reg <= diff_next;
            heat_reg <= heat_next;
            cb_reg   <= ca_reg;
            temp_reg <= temp_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = temp_reg;
    assign m_tuser[0] = sat_reg;

endmodule

// ----- hw/rtl/anisotropic_heat_stencil_cell.sv -----
// Top level of the anisotropic five-point heat diffusion stencil cell.
// Each request on the s_ channel is one interior cell: centre and four
// neighbor temperatures (signed Q16.16), a heat source and a material
// index in s_tuser. The m_ channel returns the cell temperature after one
// explicit Euler step, with m_tuser set when the result was clipped.
// Gains per material come from three 64-bit tables written through the
// cfg_we/cfg_index/cfg_data port; write them only while the block is idle.
// Path: queue, product stage, rounding stage, output register.
// Throughput: one request per cycle unless stalled, set by the single
// multiplier stage. The front end writes into a 4-entry queue; s_tready
// drops only when the queue is full. When m_tready is low with a result
// waiting, the back-end pipeline holds and the queue absorbs up to four
// more requests before backpressure reaches the input. Reset clears the
// queue, the pipeline valids and all gains.
module anisotropic_heat_stencil_cell #(
    parameter int MATERIAL_COUNT = 4,
    parameter int SOURCE_SHIFT   = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ahsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ahsc_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // centre_temp, north_temp, south_temp, east_temp, west_temp, heat_source
    input  logic [191:0]                    s_tdata,
    // material
    input  logic [ahsc_pkg::MAT_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // new_temp
    output logic [31:0]                     m_tdata,
    // saturated
    output logic [0:0]                      m_tuser
);

    logic                front_valid;
    ahsc_pkg::cell_req_t front_req;
    logic                q_valid;
    logic                q_pop;
    ahsc_pkg::cell_req_t q_req;

    ahsc_front #(
        .MATERIAL_COUNT(MATERIAL_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (front_valid),
        .req       (front_req)
    );

    ahsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (s_tready),
        .push_req   (front_req),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_req    (q_req)
    );

    ahsc_back #(
        .SOURCE_SHIFT(SOURCE_SHIFT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (q_valid),
        .req       (q_req),
        .req_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- verif/anisotropic_heat_stencil_cell_test.sv -----
// Self-checking testbench for the anisotropic heat stencil cell: directed and random cells.
`timescale 1ns / 1ps

module anisotropic_heat_stencil_cell_test;
    import ahsc_pkg::*;

    localparam int MATERIAL_COUNT = 4;
    localparam int SOURCE_SHIFT = 24;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_CELLS = 190;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int MAX_REPORTS = 10;
    localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] T_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] centre;
        logic signed [31:0] north;
        logic signed [31:0] south;
        logic signed [31:0] east;
        logic signed [31:0] west;
        logic [MAT_W-1:0]   material;
        logic [31:0]        heat_source;
    } cell_t;

    typedef struct packed {
        logic [31:0] temp;
        logic        saturated;
    } cell_result_t;

    typedef enum int {
        SHAPE_ALL_MAX,
        SHAPE_ALL_MIN,
        SHAPE_PEAK,
        SHAPE_PIT,
        SHAPE_HALF_UP,
        SHAPE_HALF_DOWN,
        SHAPE_COUNT
    } cell_shape_e;

    class cell_temp_scoreboard;
        logic [CFG_W-1:0] x_gains;
        logic [CFG_W-1:0] y_gains;
        logic [CFG_W-1:0] source_gains;
        cell_result_t     expected_temps[$];
        int               errors;

        function new();
            x_gains = '0;
            y_gains = '0;
            source_gains = '0;
            errors = 0;
        endfunction

        function void write_table(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_X_GAIN: begin
                    x_gains = data;
                end
                REG_Y_GAIN: begin
                    y_gains = data;
                end
                REG_SOURCE_GAIN: begin
                    source_gains = data;
                end
                default: begin
                end
            endcase
        endfunction

        function longint gain_of(logic [CFG_W-1:0] gains, int m);
            if (m >= MATERIAL_COUNT)
                return 64'sd0;
            return longint'(gains[16*m +: 16]);
        endfunction

        // one explicit Euler step, exact in 64 bits, then clipped
        function void note_cell(cell_t c);
            longint ctr;
            longint lap_x;
            longint lap_y;
            longint diffusion;
            longint heat;
            longint total;
            int m;
            cell_result_t r;
            m = int'(c.material);
            ctr = longint'(c.centre);
            lap_x = longint'(c.east) - 64'sd2 * ctr + longint'(c.west);
            lap_y = longint'(c.north) - 64'sd2 * ctr + longint'(c.south);
            diffusion = (gain_of(x_gains, m) * lap_x + gain_of(y_gains, m) * lap_y
                         + 64'sd32768) >>> 16;
            heat = (gain_of(source_gains, m) * longint'({32'd0, c.heat_source}))
                   >>> SOURCE_SHIFT;
            total = ctr + diffusion + heat;
            if (total > 64'sh0000_0000_7FFF_FFFF) begin
                r.temp = T_MAX;
                r.saturated = 1'b1;
            end else if (total < -64'sh0000_0000_8000_0000) begin
                r.temp = T_MIN;
                r.saturated = 1'b1;
            end else begin
                r.temp = total[31:0];
                r.saturated = 1'b0;
            end
            expected_temps.push_back(r);
        endfunction

        function void check_result(logic [31:0] temp, logic saturated);
            cell_result_t want;
            if (expected_temps.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result with no cell outstanding: new_temp %h saturated %b",
                             temp, saturated);
                return;
            end
            want = expected_temps.pop_front();
            if (temp !== want.temp || saturated !== want.saturated) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: new_temp exp %h got %h, saturated exp %b got %b",
                             want.temp, temp, want.saturated, saturated);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [191:0]         s_tdata = '0;
    logic [MAT_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic [0:0]           m_tuser;

    bit tx_gapless = 1'b0;
    bit rx_nostall = 1'b0;
    bit hold_off_pending = 1'b0;

    cell_temp_scoreboard sb;

    anisotropic_heat_stencil_cell #(
        .MATERIAL_COUNT(MATERIAL_COUNT),
        .SOURCE_SHIFT(SOURCE_SHIFT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic cell_t shaped_cell(cell_shape_e shape, int m);
        cell_t c;
        c = '0;
        c.material = MAT_W'(m);
        case (shape)
            SHAPE_ALL_MAX: begin
                c.centre = T_MAX;
                c.north = T_MAX;
                c.south = T_MAX;
                c.east = T_MAX;
                c.west = T_MAX;
                c.heat_source = '1;
            end
            SHAPE_ALL_MIN: begin
                c.centre = T_MIN;
                c.north = T_MIN;
                c.south = T_MIN;
                c.east = T_MIN;
                c.west = T_MIN;
            end
            SHAPE_PEAK: begin
                c.centre = T_MAX;
                c.north = T_MIN;
                c.south = T_MIN;
                c.east = T_MIN;
                c.west = T_MIN;
            end
            SHAPE_PIT: begin
                c.centre = T_MIN;
                c.north = T_MAX;
                c.south = T_MAX;
                c.east = T_MAX;
                c.west = T_MAX;
                c.heat_source = '1;
            end
            SHAPE_HALF_UP: begin
                c.east = 32'h0000_8000;
                c.heat_source = 32'h00FF_FFFF;
            end
            SHAPE_HALF_DOWN: begin
                c.east = 32'hFFFF_8000;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // half fully random, half a smooth field with small neighbor deltas
    function automatic cell_t random_cell();
        cell_t c;
        int unsigned spread;
        c.material = MAT_W'($urandom_range(0, 3));
        c.heat_source = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(0, 1)) begin
            c.centre = $urandom;
            c.north = $urandom;
            c.south = $urandom;
            c.east = $urandom;
            c.west = $urandom;
        end else begin
            spread = 1 << $urandom_range(0, 24);
            c.centre = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
            c.north = c.centre + $urandom_range(0, 2 * spread) - spread;
            c.south = c.centre + $urandom_range(0, 2 * spread) - spread;
            c.east = c.centre + $urandom_range(0, 2 * spread) - spread;
            c.west = c.centre + $urandom_range(0, 2 * spread) - spread;
        end
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_table(idx, data);
    endtask

    task automatic send_cell(input cell_t c);
        int gap;
        gap = tx_gapless ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.heat_source, c.west, c.east, c.south, c.north, c.centre};
        s_tuser <= c.material;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_cell(c);
    endtask

    // stop requests, wait for every result, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_temps.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all gains are zero out of reset
        send_cell(random_cell());
        drain();

        write_reg(REG_X_GAIN, 64'hFFFF_8000_0001_0000);
        write_reg(REG_Y_GAIN, 64'h0000_FFFF_0001_4000);
        write_reg(REG_SOURCE_GAIN, 64'hFFFF_0000_0100_7FFF);
        write_reg(REG_UNUSED, '1);
        for (int p = 0; p < SHAPE_COUNT; p++)
            for (int m = 0; m < 4; m++)
                send_cell(shaped_cell(cell_shape_e'(p), m));
        drain();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_X_GAIN, '1);
                    write_reg(REG_Y_GAIN, '1);
                    write_reg(REG_SOURCE_GAIN, '1);
                end
                1: begin
                    write_reg(REG_X_GAIN, '0);
                    write_reg(REG_Y_GAIN, '0);
                    write_reg(REG_SOURCE_GAIN, '0);
                end
                3: begin
                    write_reg(REG_X_GAIN, '1);
                    write_reg(REG_Y_GAIN, '0);
                    write_reg(REG_SOURCE_GAIN, {$urandom, $urandom});
                end
                4: begin
                    write_reg(REG_X_GAIN, '0);
                    write_reg(REG_Y_GAIN, '1);
                    write_reg(REG_SOURCE_GAIN, '1);
                end
                default: begin
                    write_reg(REG_X_GAIN, {$urandom, $urandom});
                    write_reg(REG_Y_GAIN, {$urandom, $urandom});
                    write_reg(REG_SOURCE_GAIN, {$urandom, $urandom});
                    if (phase == 5)
                        write_reg(REG_UNUSED, {$urandom, $urandom});
                end
            endcase
            if (phase == 2)
                hold_off_pending = 1'b1;
            for (int i = 0; i < PHASE_CELLS; i++) begin
                if (i % 40 == 0) begin
                    tx_gapless = ($urandom_range(0, 3) == 0);
                    rx_nostall = ($urandom_range(0, 3) == 0);
                end
                // keep offering while the sink holds off so the queue fills
                if (phase == 2 && i < 40)
                    tx_gapless = 1'b1;
                send_cell(random_cell());
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_temps.size() == 0)
            $display("anisotropic_heat_stencil_cell_test: clean");
        else
            $display("anisotropic_heat_stencil_cell_test: errors");
        $finish;
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_off_pending) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_pending = 1'b0;
            end else begin
                stall = rx_nostall ? 0 : $urandom_range(0, 10);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("anisotropic_heat_stencil_cell_test: errors");
        $finish;
    end

endmodule
